FILE: src/ack_retransmit_tracker_assert.svh
// Assertion macros for the ack/retransmit tracker.
// Both sample on clk and are off while rst_n is low.
`ifndef ACK_RETRANSMIT_TRACKER_ASSERT_SVH
`define ACK_RETRANSMIT_TRACKER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define ART_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/art_pkg.sv
package art_pkg;

  // Field widths
  localparam int TAG_W   = 32;
  localparam int PEER_W  = 48;
  localparam int LEN_W   = 8;
  localparam int TRIES_W = 4;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 3;
  localparam int TMO_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // At most this many results per tick request
  localparam int MAX_RESULTS = 8;
  localparam int EVT_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Request function codes (code 3 is ignored)
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_MAX = 2'd2;

  // Reset values of the configuration registers
  localparam logic [TMO_W-1:0]   RST_ACK_TIMEOUT = 16'd1000;
  localparam logic [TRIES_W-1:0] RST_RETRY_LIMIT = 4'd3;
  localparam logic [LEN_W-1:0]   RST_PAYLOAD_MAX = 8'd250;

  typedef enum logic [2:0] {
    EV_TRACKED     = 3'd0,
    EV_UNTRACKED   = 3'd1,
    EV_BAD_LEN     = 3'd2,
    EV_TABLE_FULL  = 3'd3,
    EV_ACK_CLEARED = 3'd4,
    EV_ACK_UNKNOWN = 3'd5,
    EV_RETRANSMIT  = 3'd6,
    EV_GAVE_UP     = 3'd7
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // One slot table entry as held in the RAM
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [PEER_W-1:0]  peer;
    logic [TRIES_W-1:0] tries;
    logic [TIME_W-1:0]  sent_at;
    logic [LEN_W-1:0]   len;
  } slot_entry_t;

  // One result
  typedef struct packed {
    event_kind_t        kind;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [PEER_W-1:0]  peer;
    logic [LEN_W-1:0]   len;
    logic [TRIES_W-1:0] tries;
  } result_t;

  function automatic result_t mk_result(
    input event_kind_t        kind,
    input logic [SLOT_W-1:0]  slot,
    input logic [TAG_W-1:0]   tag,
    input logic [PEER_W-1:0]  peer,
    input logic [LEN_W-1:0]   len,
    input logic [TRIES_W-1:0] tries
  );
    result_t r;
    r.kind  = kind;
    r.slot  = slot;
    r.tag   = tag;
    r.peer  = peer;
    r.len   = len;
    r.tries = tries;
    return r;
  endfunction

endpackage

FILE: src/art_ram.sv
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/ack_retransmit_tracker.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------------
// in       | in_valid / in_ready   | func, tag_present, msg_tag, dest_addr, length
// out      | out_valid / out_ready | event kind/slot/tag/peer/length/tries/last
// cfg      | cfg_we (no wait)      | cfg_index, cfg_data
//
// One request at a time; in_ready is high only while idle. Send and ack read the
// slot RAM one slot per cycle and stop at the first hit, a tick walks all slots
// unless it reaches MAX_RESULTS results. An ignored code, or a request answered
// without a scan, reads no slot; every result can wait on out_ready. The output
// register lets the next request in while the final result still waits. Sync
// reset frees all slots, zeroes the ms clock.
module ack_retransmit_tracker #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic                            in_tag_present,
  input  logic [art_pkg::TAG_W-1:0]       in_msg_tag,
  input  logic [art_pkg::PEER_W-1:0]      in_dest_addr,
  input  logic [art_pkg::LEN_W-1:0]       in_frame_length,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_event_kind,
  output logic [art_pkg::SLOT_W-1:0]      out_event_slot,
  output logic [art_pkg::TAG_W-1:0]       out_event_tag,
  output logic [art_pkg::PEER_W-1:0]      out_event_peer,
  output logic [art_pkg::LEN_W-1:0]       out_event_length,
  output logic [art_pkg::TRIES_W-1:0]     out_event_tries,
  output logic                            out_event_last,
  // configuration
  input  logic                            cfg_we,
  input  logic [art_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [art_pkg::CFG_W-1:0]       cfg_data
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W = $bits(art_pkg::slot_entry_t);
  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOT_COUNT);
  localparam logic [art_pkg::EVT_CNT_W-1:0] EVT_LAST =
    art_pkg::EVT_CNT_W'(art_pkg::MAX_RESULTS - 1);

  // Control and configuration
  art_pkg::state_t                  st_r, st_nxt;
  logic [art_pkg::TMO_W-1:0]        timeout_r;
  logic [art_pkg::TRIES_W-1:0]      limit_r;
  logic [art_pkg::LEN_W-1:0]        pmax_r;
  logic [art_pkg::TIME_W-1:0]       clock_ms_r, clock_ms_nxt;
  logic [SLOT_COUNT-1:0]            busy_r, busy_nxt;

  // Latched request
  logic [1:0]                       func_r, func_nxt;
  logic [art_pkg::TAG_W-1:0]        tag_r, tag_nxt;
  logic [art_pkg::PEER_W-1:0]       peer_r, peer_nxt;
  logic [art_pkg::LEN_W-1:0]        len_r, len_nxt;

  // Scan pipeline: issue stage and check stage
  logic [CNT_W-1:0]                 iss_idx_r, iss_idx_nxt;
  logic                             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]                 chk_idx_r, chk_idx_nxt;
  logic [art_pkg::EVT_CNT_W-1:0]    evt_cnt_r, evt_cnt_nxt;

  // Held result and output register
  logic                             hold_vld_r, hold_vld_nxt;
  art_pkg::result_t                 hold_r, hold_nxt;
  logic                             out_vld_r, out_vld_nxt;
  art_pkg::result_t                 out_r, out_nxt;
  logic                             out_last_r, out_last_nxt;

  // RAM port signals
  logic                             rd_en;
  logic [ENT_W-1:0]                 rd_data;
  logic                             wr_en;
  art_pkg::slot_entry_t             wr_ent;
  art_pkg::slot_entry_t             rd_ent;

  // Check stage decode
  logic                             busy_i;
  logic                             tag_eq;
  logic [art_pkg::TIME_W-1:0]       age;
  logic                             timed_out;
  logic                             give_up;
  logic                             tick_hit;
  logic                             stall;
  logic                             out_free;
  logic [art_pkg::SLOT_W-1:0]       slot_id;
  logic                             push;
  logic                             push_last;
  logic                             start_scan;

  art_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (chk_idx_r),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (iss_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_ent    = rd_data;
  assign busy_i    = busy_r[chk_idx_r];
  assign tag_eq    = (rd_ent.tag == tag_r);
  assign age       = clock_ms_r - rd_ent.sent_at;
  assign timed_out = (age >= {{(art_pkg::TIME_W - art_pkg::TMO_W){1'b0}}, timeout_r});
  assign give_up   = (rd_ent.tries >= limit_r);
  assign slot_id   = art_pkg::SLOT_W'(chk_idx_r);
  assign out_free  = !out_vld_r || out_ready;
  assign tick_hit  = chk_vld_r && (func_r == art_pkg::FUNC_TICK) && busy_i && timed_out;
  // a second timeout cannot proceed while hold is full and the output is full and not taken
  assign stall     = tick_hit && hold_vld_r && !out_free;

  assign in_ready  = (st_r == art_pkg::ST_IDLE);

  // Main control
  always_comb begin
    st_nxt       = st_r;
    clock_ms_nxt = clock_ms_r;
    busy_nxt     = busy_r;
    func_nxt     = func_r;
    tag_nxt      = tag_r;
    peer_nxt     = peer_r;
    len_nxt      = len_r;
    iss_idx_nxt  = iss_idx_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    evt_cnt_nxt  = evt_cnt_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    start_scan   = 1'b0;
    // new send entry by default, retransmit overrides
    wr_ent.tag     = tag_r;
    wr_ent.peer    = peer_r;
    wr_ent.tries   = '0;
    wr_ent.sent_at = clock_ms_r;
    wr_ent.len     = len_r;

    case (st_r)
      art_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          tag_nxt  = in_msg_tag;
          peer_nxt = in_dest_addr;
          len_nxt  = in_frame_length;
          case (in_func)
            art_pkg::FUNC_SEND: begin
              if ((in_frame_length == '0) || (in_frame_length > pmax_r)) begin
                hold_nxt = art_pkg::mk_result(art_pkg::EV_BAD_LEN, '0,
                  in_tag_present ? in_msg_tag : '0, in_dest_addr, in_frame_length, '0);
                hold_vld_nxt = 1'b1;
                st_nxt       = art_pkg::ST_FLUSH;
              end else if (!in_tag_present) begin
                hold_nxt = art_pkg::mk_result(art_pkg::EV_UNTRACKED, '0, '0,
                  in_dest_addr, in_frame_length, '0);
                hold_vld_nxt = 1'b1;
                st_nxt       = art_pkg::ST_FLUSH;
              end else begin
                start_scan = 1'b1;
              end
            end
            art_pkg::FUNC_ACK: begin
              if (!in_tag_present) begin
                hold_nxt = art_pkg::mk_result(art_pkg::EV_ACK_UNKNOWN, '0, '0, '0, '0, '0);
                hold_vld_nxt = 1'b1;
                st_nxt       = art_pkg::ST_FLUSH;
              end else begin
                start_scan = 1'b1;
              end
            end
            art_pkg::FUNC_TICK: begin
              clock_ms_nxt = clock_ms_r + 1'b1;
              start_scan   = 1'b1;
            end
            default: ;
          endcase
          if (start_scan) begin
            st_nxt      = art_pkg::ST_SCAN;
            iss_idx_nxt = '0;
            chk_vld_nxt = 1'b0;
            evt_cnt_nxt = '0;
          end
        end
      end

      art_pkg::ST_SCAN: begin
        // issue stage: one slot read per cycle unless stalled
        rd_en = !stall && (iss_idx_r != SLOT_END);
        if (rd_en) begin
          iss_idx_nxt = iss_idx_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_idx_r[IDX_W-1:0];
        end else if (!stall) begin
          chk_vld_nxt = 1'b0;
        end

        // check stage
        if (chk_vld_r) begin
          case (func_r)
            art_pkg::FUNC_SEND: begin
              // first free slot or one already holding the tag
              if (!busy_i || tag_eq) begin
                wr_en              = 1'b1;
                busy_nxt[chk_idx_r] = 1'b1;
                hold_nxt = art_pkg::mk_result(art_pkg::EV_TRACKED, slot_id, tag_r,
                  peer_r, len_r, '0);
                hold_vld_nxt = 1'b1;
                st_nxt       = art_pkg::ST_FLUSH;
              end
            end
            art_pkg::FUNC_ACK: begin
              if (busy_i && tag_eq) begin
                busy_nxt[chk_idx_r] = 1'b0;
                hold_nxt = art_pkg::mk_result(art_pkg::EV_ACK_CLEARED, slot_id,
                  rd_ent.tag, rd_ent.peer, rd_ent.len, rd_ent.tries);
                hold_vld_nxt = 1'b1;
                st_nxt       = art_pkg::ST_FLUSH;
              end
            end
            art_pkg::FUNC_TICK: begin
              if (tick_hit && !stall) begin
                // previous result is not the last one
                push = hold_vld_r;
                hold_vld_nxt = 1'b1;
                if (give_up) begin
                  busy_nxt[chk_idx_r] = 1'b0;
                  hold_nxt = art_pkg::mk_result(art_pkg::EV_GAVE_UP, slot_id,
                    rd_ent.tag, rd_ent.peer, rd_ent.len, rd_ent.tries);
                end else begin
                  wr_en         = 1'b1;
                  wr_ent.tag    = rd_ent.tag;
                  wr_ent.peer   = rd_ent.peer;
                  wr_ent.tries  = rd_ent.tries + 1'b1;
                  wr_ent.len    = rd_ent.len;
                  hold_nxt = art_pkg::mk_result(art_pkg::EV_RETRANSMIT, slot_id,
                    rd_ent.tag, rd_ent.peer, rd_ent.len, rd_ent.tries + 1'b1);
                end
                evt_cnt_nxt = evt_cnt_r + 1'b1;
                if (evt_cnt_r == EVT_LAST) begin
                  st_nxt = art_pkg::ST_FLUSH;
                end
              end
            end
            default: ;
          endcase
        end else if (iss_idx_r == SLOT_END) begin
          // walked every slot; a send or ack found no hit
          case (func_r)
            art_pkg::FUNC_SEND: begin
              hold_nxt = art_pkg::mk_result(art_pkg::EV_TABLE_FULL, '0, tag_r,
                peer_r, len_r, '0);
              hold_vld_nxt = 1'b1;
            end
            art_pkg::FUNC_ACK: begin
              hold_nxt = art_pkg::mk_result(art_pkg::EV_ACK_UNKNOWN, '0, tag_r,
                '0, '0, '0);
              hold_vld_nxt = 1'b1;
            end
            default: ;
          endcase
          st_nxt = art_pkg::ST_FLUSH;
        end
      end

      art_pkg::ST_FLUSH: begin
        // final result goes out flagged as last
        if (!hold_vld_r) begin
          st_nxt = art_pkg::ST_IDLE;
        end else if (out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          hold_vld_nxt = 1'b0;
          st_nxt       = art_pkg::ST_IDLE;
        end
      end

      default: begin
        st_nxt = art_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_nxt      = hold_r;
      out_last_nxt = push_last;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= art_pkg::ST_IDLE;
      clock_ms_r <= '0;
      busy_r     <= '0;
      iss_idx_r  <= '0;
      chk_vld_r  <= 1'b0;
      evt_cnt_r  <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clock_ms_r <= clock_ms_nxt;
      busy_r     <= busy_nxt;
      iss_idx_r  <= iss_idx_nxt;
      chk_vld_r  <= chk_vld_nxt;
      evt_cnt_r  <= evt_cnt_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    tag_r      <= tag_nxt;
    peer_r     <= peer_nxt;
    len_r      <= len_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= art_pkg::RST_ACK_TIMEOUT;
      limit_r   <= art_pkg::RST_RETRY_LIMIT;
      pmax_r    <= art_pkg::RST_PAYLOAD_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        art_pkg::CFG_ACK_TIMEOUT: timeout_r <= cfg_data;
        art_pkg::CFG_RETRY_LIMIT: limit_r   <= cfg_data[art_pkg::TRIES_W-1:0];
        art_pkg::CFG_PAYLOAD_MAX: pmax_r    <= cfg_data[art_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_kind   = out_r.kind;
  assign out_event_slot   = out_r.slot;
  assign out_event_tag    = out_r.tag;
  assign out_event_peer   = out_r.peer;
  assign out_event_length = out_r.len;
  assign out_event_tries  = out_r.tries;
  assign out_event_last   = out_last_r;

  // Checks
  `include "ack_retransmit_tracker_assert.svh"

  `ART_ASSERT_SAME(a_idle_hold_empty, st_r == art_pkg::ST_IDLE, !hold_vld_r, "hold full at idle")
  `ART_ASSERT_NEXT(a_busy_only_in_scan, st_r != art_pkg::ST_SCAN, $stable(busy_r), "busy moved")
  `ART_ASSERT_NEXT(a_stall_keeps_check, stall, chk_vld_r && $stable(chk_idx_r), "check lost")

endmodule
